[rtl/core/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder unit.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   // Result kinds as they appear on the result channel.
   localparam logic [1:0] KIND_UNIT     = 2'd0;
   localparam logic [1:0] KIND_OK       = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_ONLY   = 1'b1;

   localparam logic [30:0] LIMIT_RESET = 31'h7FFF_FFFF;

   // Byte classes.
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;

   localparam logic [2:0] SEQ_LEN_TWO   = 3'd2;
   localparam logic [2:0] SEQ_LEN_THREE = 3'd3;
   localparam logic [2:0] SEQ_LEN_FOUR  = 3'd4;

   // Smallest values that are not overlong.
   localparam logic [10:0] MIN_TWO   = 11'h080;
   localparam logic [15:0] MIN_THREE = 16'h0800;
   localparam logic [20:0] MIN_FOUR  = 21'h10000;

   localparam logic [15:0] SURR_HIGH = 16'hD800;
   localparam logic [15:0] SURR_LOW  = 16'hDC00;

   localparam int MAX_OPS    = 5;
   localparam int OP_COUNT_W = 3;

   // One emit step of the back part.
   typedef enum logic [1:0] {
      OP_UNIT,
      OP_PAIR_HI,
      OP_PAIR_LO,
      OP_SUMMARY
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [15:0] value;
   } op_type;

   // All emit steps caused by one input byte.
   typedef struct packed {
      op_type [MAX_OPS-1:0]  ops;
      logic [OP_COUNT_W-1:0] op_count;
   } item_type;

   typedef struct packed {
      logic [30:0] output_limit;
      logic        count_only;
   } cfg_type;

endpackage

[rtl/core/u8u16_front.sv]
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts bytes, gathers multi-byte sequences and turns each byte into a
// list of emit steps for the back part.
// ----------------------------------------------------------------------------
module u8u16_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_byte_value,
   input  logic                req_last_byte,
   input  logic                queue_full,
   output logic                push_valid,
   output u8u16_pkg::item_type push_item
);

   logic [7:0] pend_ff [3];
   logic [7:0] pend_in [3];
   logic [1:0] pend_count_ff, pend_count_in;
   logic [2:0] need_len_ff, need_len_in;

   logic        accept;
   logic        have, is_cont, seq_done, seq_grow, broken, fresh, fresh_lead;
   logic        seq_ok, seq_bad, hold_new, grow_keep, flush_old, main_raw;
   logic [10:0] val_two;
   logic [15:0] val_three;
   logic [20:0] val_four, diff_four;
   logic        ok_value;
   logic [15:0] surr_hi, surr_lo, short_value;
   logic [2:0]  lead_len;
   logic [2:0]  idx;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign have     = pend_count_ff != 2'd0;
   assign is_cont  = (req_byte_value & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG;
   assign seq_done = have && is_cont && (({1'b0, pend_count_ff} + 3'd1) >= need_len_ff);
   assign seq_grow = have && is_cont && !seq_done;
   assign broken   = have && !is_cont;
   assign fresh    = !have || broken;
   assign fresh_lead = req_byte_value >= u8u16_pkg::LEAD_TWO;

   assign val_two   = {pend_ff[0][4:0], req_byte_value[5:0]};
   assign val_three = {pend_ff[0][3:0], pend_ff[1][5:0], req_byte_value[5:0]};
   assign val_four  = {pend_ff[0][2:0], pend_ff[1][5:0], pend_ff[2][5:0],
                       req_byte_value[5:0]};
   assign diff_four = val_four - u8u16_pkg::MIN_FOUR;
   assign surr_hi   = u8u16_pkg::SURR_HIGH + {6'd0, diff_four[19:10]};
   assign surr_lo   = u8u16_pkg::SURR_LOW + {6'd0, diff_four[9:0]};

   always_comb begin
      case (need_len_ff)
         u8u16_pkg::SEQ_LEN_TWO: begin
            ok_value    = val_two >= u8u16_pkg::MIN_TWO;
            short_value = {5'd0, val_two};
         end
         u8u16_pkg::SEQ_LEN_THREE: begin
            ok_value    = val_three >= u8u16_pkg::MIN_THREE;
            short_value = val_three;
         end
         default: begin
            ok_value    = val_four >= u8u16_pkg::MIN_FOUR;
            short_value = val_three;
         end
      endcase
   end

   always_comb begin
      if (req_byte_value < u8u16_pkg::LEAD_THREE) begin
         lead_len = u8u16_pkg::SEQ_LEN_TWO;
      end else if (req_byte_value < u8u16_pkg::LEAD_FOUR) begin
         lead_len = u8u16_pkg::SEQ_LEN_THREE;
      end else begin
         lead_len = u8u16_pkg::SEQ_LEN_FOUR;
      end
   end

   assign seq_ok    = seq_done && ok_value;
   assign seq_bad   = seq_done && !ok_value;
   assign hold_new  = fresh && fresh_lead && !req_last_byte;
   assign grow_keep = seq_grow && !req_last_byte;
   // Pending bytes go out raw on a broken or overlong sequence, or when the
   // string ends in the middle of one.
   assign flush_old = seq_bad || broken || (seq_grow && req_last_byte);
   assign main_raw  = (fresh && !hold_new) || seq_bad || (seq_grow && req_last_byte);

   always_comb begin
      push_item = '0;
      idx       = '0;
      if (flush_old) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < pend_count_ff) begin
               push_item.ops[idx].kind  = u8u16_pkg::OP_UNIT;
               push_item.ops[idx].value = {8'd0, pend_ff[i]};
               idx = idx + 3'd1;
            end
         end
      end
      if (seq_ok) begin
         if (need_len_ff == u8u16_pkg::SEQ_LEN_TWO || need_len_ff == u8u16_pkg::SEQ_LEN_THREE)
         begin
            push_item.ops[idx].kind  = u8u16_pkg::OP_UNIT;
            push_item.ops[idx].value = short_value;
            idx = idx + 3'd1;
         end else begin
            push_item.ops[idx].kind  = u8u16_pkg::OP_PAIR_HI;
            push_item.ops[idx].value = surr_hi;
            idx = idx + 3'd1;
            push_item.ops[idx].kind  = u8u16_pkg::OP_PAIR_LO;
            push_item.ops[idx].value = surr_lo;
            idx = idx + 3'd1;
         end
      end
      if (main_raw) begin
         push_item.ops[idx].kind  = u8u16_pkg::OP_UNIT;
         push_item.ops[idx].value = {8'd0, req_byte_value};
         idx = idx + 3'd1;
      end
      if (req_last_byte) begin
         push_item.ops[idx].kind  = u8u16_pkg::OP_SUMMARY;
         push_item.ops[idx].value = '0;
         idx = idx + 3'd1;
      end
      push_item.op_count = idx;
   end

   assign push_valid = accept && (push_item.op_count != '0);

   always_comb begin
      pend_in       = pend_ff;
      pend_count_in = pend_count_ff;
      need_len_in   = need_len_ff;
      if (accept) begin
         if (hold_new) begin
            pend_in[0]    = req_byte_value;
            pend_count_in = 2'd1;
            need_len_in   = lead_len;
         end else if (grow_keep) begin
            pend_in[pend_count_ff] = req_byte_value;
            pend_count_in          = pend_count_ff + 2'd1;
         end else begin
            pend_count_in = '0;
            need_len_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         pend_count_ff <= '0;
         need_len_ff   <= '0;
      end else begin
         pend_count_ff <= pend_count_in;
         need_len_ff   <= need_len_in;
      end
   end

endmodule

[rtl/core/u8u16_queue.sv]
// ----------------------------------------------------------------------------
// u8u16_queue
// Short queue of step lists between the front and the back part.
// ----------------------------------------------------------------------------
module u8u16_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  u8u16_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output u8u16_pkg::item_type head_item
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR   = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   u8u16_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = count_ff == FULL_COUNT;
   assign head_valid = count_ff != '0;
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/u8u16_back.sv]
// ----------------------------------------------------------------------------
// u8u16_back
// Carries out emit steps one per cycle unless the result channel stalls;
// applies the output limit, counts units, builds summaries and drives that channel.
// ----------------------------------------------------------------------------
module u8u16_back (
   input  logic                clock,
   input  logic                reset,
   input  u8u16_pkg::cfg_type  cfg,
   input  logic                head_valid,
   input  u8u16_pkg::item_type head_item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [15:0]         rsp_unit_value,
   output logic [31:0]         rsp_unit_total,
   output logic                rsp_end_of_run
);

   logic [u8u16_pkg::OP_COUNT_W-1:0] op_idx_ff, op_idx_in;
   logic [31:0] units_ff, units_in;
   logic        ovf_ff, ovf_in;
   logic        pair_ok_ff, pair_ok_in;

   // Hold stage: a result waits here until it is known whether it is the
   // last one of its byte.
   logic        hold_valid_ff, hold_valid_in;
   logic        hold_final_ff, hold_final_in;
   logic [1:0]  hold_kind_ff, hold_kind_in;
   logic [15:0] hold_unit_ff, hold_unit_in;
   logic [31:0] hold_total_ff, hold_total_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_eor_ff, out_eor_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [15:0] out_unit_ff, out_unit_in;
   logic [31:0] out_total_ff, out_total_in;

   u8u16_pkg::op_type cur_op;
   logic        last_op, produces, advance, out_free, hold_rel;
   logic [32:0] sum;
   logic [31:0] sat_sum;
   logic        fits;
   logic [1:0]  new_kind;
   logic [15:0] new_unit;
   logic [31:0] new_total;

   assign cur_op  = head_item.ops[op_idx_ff];
   assign last_op = op_idx_ff == (head_item.op_count - 3'd1);

   assign sum     = {1'b0, units_ff} + ((cur_op.kind == u8u16_pkg::OP_PAIR_HI) ? 33'd2 : 33'd1);
   assign sat_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign fits    = sum <= {2'b00, cfg.output_limit};

   always_comb begin
      case (cur_op.kind)
         u8u16_pkg::OP_UNIT, u8u16_pkg::OP_PAIR_HI: produces = !cfg.count_only && !ovf_ff && fits;
         u8u16_pkg::OP_PAIR_LO:                     produces = pair_ok_ff && !cfg.count_only;
         u8u16_pkg::OP_SUMMARY:                     produces = 1'b1;
         default:                                   produces = 1'b0;
      endcase
   end

   always_comb begin
      if (cur_op.kind == u8u16_pkg::OP_SUMMARY) begin
         new_kind  = ovf_ff ? u8u16_pkg::KIND_OVERFLOW : u8u16_pkg::KIND_OK;
         new_unit  = '0;
         new_total = ovf_ff ? 32'd0 : units_ff;
      end else begin
         new_kind  = u8u16_pkg::KIND_UNIT;
         new_unit  = cur_op.value;
         new_total = '0;
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign hold_rel = hold_valid_ff && out_free &&
                     (hold_final_ff || (head_valid && produces));
   assign advance  = head_valid && (!produces || !hold_valid_ff || hold_rel);
   assign pop      = advance && last_op;

   always_comb begin
      op_idx_in  = op_idx_ff;
      units_in   = units_ff;
      ovf_in     = ovf_ff;
      pair_ok_in = pair_ok_ff;
      if (advance) begin
         op_idx_in = last_op ? '0 : op_idx_ff + 3'd1;
         case (cur_op.kind)
            u8u16_pkg::OP_UNIT, u8u16_pkg::OP_PAIR_HI: begin
               if (cfg.count_only) begin
                  units_in = sat_sum;
               end else if (!ovf_ff) begin
                  if (fits) begin
                     units_in = sum[31:0];
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (cur_op.kind == u8u16_pkg::OP_PAIR_HI) begin
                  pair_ok_in = produces;
               end
            end
            u8u16_pkg::OP_SUMMARY: begin
               units_in = '0;
               ovf_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_final_in = hold_final_ff;
      hold_kind_in  = hold_kind_ff;
      hold_unit_in  = hold_unit_ff;
      hold_total_in = hold_total_ff;
      if (advance && produces) begin
         hold_valid_in = 1'b1;
         hold_final_in = last_op;
         hold_kind_in  = new_kind;
         hold_unit_in  = new_unit;
         hold_total_in = new_total;
      end else begin
         if (hold_rel) begin
            hold_valid_in = 1'b0;
         end
         if (advance && last_op) begin
            hold_final_in = 1'b1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_eor_in   = out_eor_ff;
      out_kind_in  = out_kind_ff;
      out_unit_in  = out_unit_ff;
      out_total_in = out_total_ff;
      if (hold_rel) begin
         out_valid_in = 1'b1;
         out_eor_in   = hold_final_ff;
         out_kind_in  = hold_kind_ff;
         out_unit_in  = hold_unit_ff;
         out_total_in = hold_total_ff;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      hold_kind_ff  <= hold_kind_in;
      hold_unit_ff  <= hold_unit_in;
      hold_total_ff <= hold_total_in;
      out_eor_ff    <= out_eor_in;
      out_kind_ff   <= out_kind_in;
      out_unit_ff   <= out_unit_in;
      out_total_ff  <= out_total_in;
      if (reset) begin
         op_idx_ff     <= '0;
         units_ff      <= '0;
         ovf_ff        <= 1'b0;
         pair_ok_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         hold_final_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         op_idx_ff     <= op_idx_in;
         units_ff      <= units_in;
         ovf_ff        <= ovf_in;
         pair_ok_ff    <= pair_ok_in;
         hold_valid_ff <= hold_valid_in;
         hold_final_ff <= hold_final_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_unit_value = out_unit_ff;
   assign rsp_unit_total = out_total_ff;
   assign rsp_end_of_run = out_eor_ff;

endmodule

[rtl/core/utf8_to_utf16_decoder_unit.sv]
// Path: queue, hold stage, output register; a byte's results wait behind every
// emit step queued ahead of them. Throughput: one byte per cycle while bytes
// queue at most one emit step each and the result channel does not stall; a
// byte that queues more steps (units, surrogate halves and summaries, also those
// suppressed by the limit or count-only mode) holds the back part for each in turn.
// Reset: synchronous, clears queue, sequence and counters; registers to reset.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit
// UTF-8 to UTF-16 transcoder with an output limit and a count-only mode.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_byte_value,
   input  logic                                   req_last_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_kind,
   output logic [15:0]                            rsp_unit_value,
   output logic [31:0]                            rsp_unit_total,
   output logic                                   rsp_end_of_run,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [u8u16_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [u8u16_pkg::CSR_DATA_W-1:0]       csr_data
);

   u8u16_pkg::cfg_type  cfg_ff, cfg_in;
   u8u16_pkg::item_type push_item, head_item;
   logic                push_valid, queue_full, pop, head_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            u8u16_pkg::CSR_OUTPUT_LIMIT: cfg_in.output_limit = csr_data[30:0];
            u8u16_pkg::CSR_COUNT_ONLY:   cfg_in.count_only   = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_limit <= u8u16_pkg::LIMIT_RESET;
         cfg_ff.count_only   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   u8u16_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_item      (push_item)
   );

   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   u8u16_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_unit_value (rsp_unit_value),
      .rsp_unit_total (rsp_unit_total),
      .rsp_end_of_run (rsp_end_of_run)
   );

endmodule

[sim/u8u16_stream_checker.sv]
// ----------------------------------------------------------------------------
// u8u16_stream_checker
// Watches the byte, result and register channels of the UTF-8 to UTF-16
// decoder unit. It keeps its own copy of the decoding state, works out the
// code units and string summaries that each accepted byte must cause, and
// compares every result beat against them in order.
// ----------------------------------------------------------------------------
module u8u16_stream_checker
   import u8u16_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_byte_value,
   input  logic                   req_last_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_kind,
   input  logic [15:0]            rsp_unit_value,
   input  logic [31:0]            rsp_unit_total,
   input  logic                   rsp_end_of_run,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     awaited_count,
   output int                     results_seen,
   output int                     overflow_summaries
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] unit_value;
      logic [31:0] unit_total;
      logic        end_of_run;
   } utf16_result_t;

   logic [30:0]   limit_copy      = LIMIT_RESET;
   logic          count_only_copy = 1'b0;
   logic [7:0]    seq_bytes [3];
   logic [1:0]    seq_held        = '0;
   logic [2:0]    seq_len         = '0;
   logic [31:0]   string_units    = '0;
   logic          string_overflow = 1'b0;
   utf16_result_t awaited_results [$];
   utf16_result_t byte_results [$];

   function automatic void add_result(input logic [1:0] kind, input logic [15:0] value,
                                      input logic [31:0] total);
      utf16_result_t r;
      r.kind       = kind;
      r.unit_value = value;
      r.unit_total = total;
      r.end_of_run = 1'b0;
      if (byte_results.size() < MAX_OPS) byte_results.push_back(r);
   endfunction

   // Counts n units against the string; in count-only mode the total saturates,
   // otherwise units that do not fit under the limit mark the string overflowed.
   function automatic void put_units(input logic [15:0] first_unit,
                                     input logic [15:0] second_unit, input int unsigned n);
      logic [32:0] grown;
      grown = {1'b0, string_units} + 33'(n);
      if (count_only_copy) begin
         string_units = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
      end else if (!string_overflow) begin
         if (grown > {2'b00, limit_copy}) begin
            string_overflow = 1'b1;
         end else begin
            add_result(KIND_UNIT, first_unit, 32'd0);
            if (n > 1) add_result(KIND_UNIT, second_unit, 32'd0);
            string_units = grown[31:0];
         end
      end
   endfunction

   function automatic void flush_held();
      for (int i = 0; i < seq_held; i++) put_units({8'h00, seq_bytes[i]}, 16'h0000, 1);
      seq_held = '0;
      seq_len  = '0;
   endfunction

   function automatic void start_fresh(input logic [7:0] value);
      if (value < LEAD_TWO) begin
         put_units({8'h00, value}, 16'h0000, 1);
      end else begin
         seq_bytes[0] = value;
         seq_held     = 2'd1;
         seq_len      = (value < LEAD_THREE) ? SEQ_LEN_TWO :
                        (value < LEAD_FOUR)  ? SEQ_LEN_THREE : SEQ_LEN_FOUR;
      end
   endfunction

   function automatic void complete_sequence(input logic [7:0] value);
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [20:0] code;
      logic [20:0] offset;
      logic        wide;
      logic        ok;
      p1   = (seq_held > 2'd1) ? seq_bytes[1] : 8'h00;
      p2   = (seq_held > 2'd2) ? seq_bytes[2] : 8'h00;
      wide = 1'b0;
      case (seq_len)
         SEQ_LEN_TWO: begin
            code = {10'd0, seq_bytes[0][4:0], value[5:0]};
            ok   = code >= MIN_TWO;
         end
         SEQ_LEN_THREE: begin
            code = {5'd0, seq_bytes[0][3:0], p1[5:0], value[5:0]};
            ok   = code >= MIN_THREE;
         end
         default: begin
            code = {seq_bytes[0][2:0], p1[5:0], p2[5:0], value[5:0]};
            ok   = code >= MIN_FOUR;
            wide = 1'b1;
         end
      endcase
      if (!ok) begin
         // Overlong: every byte of the sequence goes out raw.
         flush_held();
         put_units({8'h00, value}, 16'h0000, 1);
      end else begin
         if (wide) begin
            // Code points above 0x10FFFF wrap through the 10-bit fields.
            offset = code - MIN_FOUR;
            put_units(SURR_HIGH + 16'(offset[19:10]), SURR_LOW + 16'(offset[9:0]), 2);
         end else begin
            put_units(code[15:0], 16'h0000, 1);
         end
         seq_held = '0;
         seq_len  = '0;
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] value, input logic last_flag);
      byte_results.delete();
      if (seq_held != 0) begin
         if ((value & CONT_MASK) == CONT_TAG) begin
            if (seq_held + 3'd1 >= seq_len) begin
               complete_sequence(value);
            end else begin
               seq_bytes[seq_held] = value;
               seq_held            = seq_held + 2'd1;
            end
         end else begin
            flush_held();
            start_fresh(value);
         end
      end else begin
         start_fresh(value);
      end
      if (last_flag) begin
         flush_held();
         if (string_overflow) add_result(KIND_OVERFLOW, 16'h0000, 32'd0);
         else add_result(KIND_OK, 16'h0000, string_units);
         string_units    = '0;
         string_overflow = 1'b0;
      end
      if (byte_results.size() > 0) byte_results[byte_results.size()-1].end_of_run = 1'b1;
      foreach (byte_results[i]) awaited_results.push_back(byte_results[i]);
   endfunction

   function automatic void check_field(input string field_name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field_name, want_v, got_v);
         fail_count++;
      end
   endfunction

   function automatic void check_result();
      utf16_result_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
         $error("result beat with nothing expected: kind %0d unit 0x%0h total %0d end %0b",
                rsp_kind, rsp_unit_value, rsp_unit_total, rsp_end_of_run);
         fail_count++;
      end else begin
         want = awaited_results.pop_front();
         if (want.kind == KIND_OVERFLOW) overflow_summaries++;
         check_field("kind", 32'(want.kind), 32'(rsp_kind));
         check_field("unit_value", 32'(want.unit_value), 32'(rsp_unit_value));
         check_field("unit_total", want.unit_total, rsp_unit_total);
         check_field("end_of_run", 32'(want.end_of_run), 32'(rsp_end_of_run));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         limit_copy      = LIMIT_RESET;
         count_only_copy = 1'b0;
         seq_held        = '0;
         seq_len         = '0;
         string_units    = '0;
         string_overflow = 1'b0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OUTPUT_LIMIT: limit_copy = csr_data[30:0];
               CSR_COUNT_ONLY:   count_only_copy = csr_data[0];
               default: ;
            endcase
         end
         // A byte accepted now cannot have a result out yet, so check first.
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) decode_byte(req_byte_value, req_last_byte);
      end
      awaited_count = awaited_results.size();
   end

endmodule

[sim/utf8_to_utf16_decoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit_tb
// Feeds UTF-8 strings to the decoder unit: a directed set of corner cases,
// then random strings of mostly well-formed characters mixed with overlong,
// truncated and stray bytes, under several output-limit and count-only
// settings. Both channels idle at random outside one steady phase; the stream checker does the rest.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import u8u16_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AT_BYTE  = 60;
   localparam int PHASE_COUNT   = 6;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_byte_value = '0;
   logic                   req_last_byte  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [1:0]             rsp_kind;
   logic [15:0]            rsp_unit_value;
   logic [31:0]            rsp_unit_total;
   logic                   rsp_end_of_run;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = CSR_OUTPUT_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   int fail_count;
   int awaited_count;
   int results_seen;
   int overflow_summaries;

   int          bytes_sent   = 0;
   int          strings_sent = 0;
   int          cycle_count  = 0;
   logic        steady_phase = 1'b0;
   logic        rsp_hold     = 1'b0;
   logic        stall_phase  = 1'b0;
   int unsigned stall_run    = 0;
   logic [7:0]  text_q [$];

   utf8_to_utf16_decoder_unit dut (.*);

   u8u16_stream_checker stream_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned idle_length();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   // Receiver: alternating runs of ready and stalled cycles.
   always @(negedge clock) begin
      if (stall_run != 0) begin
         stall_run--;
      end else begin
         stall_phase = !stall_phase && !steady_phase;
         stall_run   = stall_phase ? idle_length() : $urandom_range(1, 12);
      end
      rsp_stall <= stall_phase || rsp_hold;
   end

   // Long receiver hold-off while bytes keep coming, to back the unit up.
   initial begin
      wait (bytes_sent >= HOLD_AT_BYTE);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("run stopped after %0d cycles with %0d results outstanding",
             cycle_count, awaited_count);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value, input logic last_flag);
      int unsigned gap;
      gap = (steady_phase || $urandom_range(0, 99) < 70) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= value;
      req_last_byte  <= last_flag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      strings_sent++;
      text_q.delete();
   endtask

   task automatic send_packed(input logic [63:0] bytes, input int count);
      for (int i = count - 1; i >= 0; i--) text_q.push_back(bytes[8*i +: 8]);
      send_text();
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (awaited_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Appends one character: mostly valid encodings of each length, the rest
   // overlong forms, truncated sequences, stray continuations and noise.
   function automatic void add_char();
      int unsigned pick;
      int unsigned conts;
      logic [31:0] r;
      pick  = $urandom_range(0, 99);
      r     = $urandom();
      conts = 0;
      if (pick < 30) begin
         text_q.push_back({1'b0, r[6:0]});
      end else if (pick < 44) begin
         text_q.push_back({3'b110, r[4:0]});
         conts = 1;
      end else if (pick < 58) begin
         text_q.push_back({4'b1110, r[3:0]});
         conts = 2;
      end else if (pick < 72) begin
         text_q.push_back({4'b1111, r[3:0]});
         conts = 3;
      end else if (pick < 78) begin
         case ($urandom_range(0, 2))
            0: begin
               text_q.push_back({7'b1100000, r[0]});
               conts = 1;
            end
            1: begin
               text_q.push_back(LEAD_THREE);
               text_q.push_back({3'b100, r[8:4]});
               conts = 1;
            end
            default: begin
               text_q.push_back(LEAD_FOUR);
               text_q.push_back({4'b1000, r[7:4]});
               conts = 2;
            end
         endcase
      end else if (pick < 88) begin
         text_q.push_back({2'b11, r[5:0]});
         conts = r[5] ? $urandom_range(0, r[4] ? 2 : 1) : 0;
      end else if (pick < 94) begin
         text_q.push_back({2'b10, r[5:0]});
      end else begin
         text_q.push_back(r[7:0]);
      end
      repeat (conts) text_q.push_back({2'b10, 6'($urandom())});
   endfunction

   initial begin
      int          phase_start;
      int          quota;
      logic [30:0] limit_value;
      logic        count_mode;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // ASCII bounds, a lone continuation, an overlong and a valid pair.
      send_packed(64'h00_7F_BF_C0_80_C3_A9, 7);
      // Overlong three-byte form, then a surrogate passed straight through.
      send_packed(64'hE0_80_80_ED_A0_80, 6);
      // Valid four-byte character, then the largest value that wraps.
      send_packed(64'hF0_9F_98_80_FF_BF_BF_BF, 8);
      // Sequence broken by a new lead, which the string end then flushes.
      send_packed(64'hF0_9F_98_F0, 4);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         count_mode  = 1'b0;
         limit_value = LIMIT_RESET;
         case (phase)
            0: quota = 90;
            1: begin
               limit_value = '0;
               quota       = 40;
            end
            2: begin
               limit_value = 31'($urandom_range(1, 6));
               quota       = 70;
            end
            3: begin
               limit_value = '0;
               count_mode  = 1'b1;
               quota       = 50;
            end
            4: begin
               count_mode = 1'b1;
               quota      = 40;
            end
            default: begin
               limit_value = 31'($urandom());
               quota       = 55;
            end
         endcase
         if (phase > 0) begin
            req_valid <= 1'b0;
            wait_idle();
            write_reg(CSR_OUTPUT_LIMIT, {1'($urandom()), limit_value});
            write_reg(CSR_COUNT_ONLY, {31'($urandom()), count_mode});
            csr_valid <= 1'b0;
         end
         steady_phase <= (phase == 4);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < quota) begin
            repeat ($urandom_range(1, 6)) add_char();
            send_text();
         end
      end

      req_valid <= 1'b0;
      wait_idle();

      $display("Sent %0d bytes in %0d strings across %0d register settings.",
               bytes_sent, strings_sent, PHASE_COUNT);
      $display("Compared %0d result beats; %0d strings ended in an output-limit overflow.",
               results_seen, overflow_summaries);
      if (fail_count == 0 && awaited_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
